// ----- hdl/rcst_pkg.sv -----
// ----------------------------------------------------------------------------
// rcst_pkg - shared definitions for the subscription table
// Sizes, operation and status codes, and stream packing widths.
// ----------------------------------------------------------------------------
package rcst_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int MAX_BITS    = 16;
	localparam int CNT_W       = 15;
	localparam int ROW_W       = MAX_BITS * CNT_W;
	localparam int NB_W        = $clog2(MAX_BITS + 1);

	// item fields
	localparam int MODE_W   = 2;
	localparam int KEY_W    = 16;
	localparam int MASK_W   = MAX_BITS;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 5;

	// stream data widths, padded to whole bytes
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

	typedef enum logic [MODE_W-1:0] {
		MODE_SUB   = 2'd0,
		MODE_UNSUB = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

endpackage

// ----- hdl/rcst_ram.sv -----
// ----------------------------------------------------------------------------
// rcst_ram - generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module rcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read; a read of the address being written returns old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/ref_counted_subscription_table.sv -----
// ----------------------------------------------------------------------------
// ref_counted_subscription_table - keyed table of per-object reference counters
// Subscribe, unsubscribe, query and clear on up to 64 objects, 16 counters each.
// ----------------------------------------------------------------------------
// One input transfer can be taken in every clock cycle, and each gives exactly
// one result transfer. Stage one matches the object id against all keys and
// picks the lowest free slot, then reads the entry's counter row from a
// 64 x 240-bit RAM with one read and one write port; stage two updates the
// row, writes it back and registers the result. A row written back in the
// same cycle as the next item's read is forwarded, and a slot freed by stage
// two is seen as free by stage one at once. Backpressure on the result side
// stalls both stages and the input. The active_bits register is to be written
// only while the block is idle, by the user; the block does not enforce this.
module ref_counted_subscription_table (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: active_bits
	input  logic                                cfg_wr_en,
	input  logic [rcst_pkg::CFG_W-1:0]          cfg_wr_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// fields from bit 0: mode[1:0], object_id[17:2], bit_mask[33:18], zero pad
	input  logic [rcst_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// fields from bit 0: is_subscribed[0], status[3:1], entry_removed[4], zero pad
	output logic [rcst_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

	localparam int TD   = rcst_pkg::TABLE_DEPTH;
	localparam int SW   = rcst_pkg::SLOT_W;
	localparam int NB   = rcst_pkg::MAX_BITS;
	localparam int CW   = rcst_pkg::CNT_W;
	localparam int RW   = rcst_pkg::ROW_W;
	localparam int KW   = rcst_pkg::KEY_W;
	localparam int MW   = rcst_pkg::MASK_W;
	localparam int NBW  = rcst_pkg::NB_W;
	localparam int MDW  = rcst_pkg::MODE_W;

	// configuration and table directory
	logic [rcst_pkg::CFG_W-1:0] active_bits_q;
	logic [TD-1:0]              entry_vld_q;
	logic [TD-1:0]              entry_vld_nxt;
	logic [KW-1:0]              entry_key_q [TD];

	// stage one
	logic                  vld_s1;
	rcst_pkg::mode_t       mode_s1;
	logic [KW-1:0]         key_s1;
	logic [MW-1:0]         mask_s1;

	// stage two
	logic                  vld_s2;
	rcst_pkg::mode_t       mode_s2;
	logic [MW-1:0]         mask_s2;
	logic [SW-1:0]         slot_s2;
	logic                  found_s2;
	logic                  new_s2;
	logic                  fwd_s2;
	logic [RW-1:0]         fwd_row_s2;

	// result register
	logic                          out_vld_q;
	logic [rcst_pkg::M_TDATA_W-1:0] out_data_q;

	// handshake
	logic s1_adv, s2_adv, in_xfer;

	// stage one lookup
	logic [TD-1:0] eff_vld;
	logic [TD-1:0] match_vec;
	logic          hit, any_free, alloc, found_s1;
	logic [SW-1:0] hit_slot, free_slot, slot_s1;

	// stage two datapath
	logic [RW-1:0]         rd_row, row_cur, row_sub, row_uns, row_wr;
	logic [NBW-1:0]        used_bits;
	logic [NB-1:0]         lane_en;
	logic                  sat, uflow, all_zero, q_ok;
	logic                  s2_wr, s2_rm;
	rcst_pkg::status_t     status;
	logic                  subscribed;

	// ---------------- handshake ----------------
	assign s2_adv        = vld_s2 && (!out_vld_q || m_axis_tready);
	assign s1_adv        = vld_s1 && (!vld_s2 || s2_adv);
	assign s_axis_tready = !vld_s1 || s1_adv;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- stage one: key match and free slot ----------------
	// treat a slot that stage two frees in this cycle as already free
	always_comb begin
		eff_vld = entry_vld_q;
		if (s2_rm) begin
			eff_vld[slot_s2] = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < TD; i++) begin
			match_vec[i] = eff_vld[i] && (entry_key_q[i] == key_s1);
		end
	end

	// pick the lowest matching slot and the lowest free slot
	always_comb begin
		hit       = 1'b0;
		hit_slot  = '0;
		any_free  = 1'b0;
		free_slot = '0;
		for (int i = TD - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit      = 1'b1;
				hit_slot = SW'(i);
			end
			if (!eff_vld[i]) begin
				any_free  = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	assign alloc    = (mode_s1 == rcst_pkg::MODE_SUB) && !hit && any_free;
	assign found_s1 = hit || alloc;
	assign slot_s1  = hit ? hit_slot : free_slot;

	// ---------------- counter row memory ----------------
	rcst_ram #(
		.WIDTH (RW),
		.DEPTH (TD)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (s2_adv && s2_wr),
		.wr_addr (slot_s2),
		.wr_data (row_wr),
		.rd_en   (s1_adv),
		.rd_addr (slot_s1),
		.rd_data (rd_row)
	);

	// ---------------- stage two: counter update ----------------
	assign used_bits = (active_bits_q > rcst_pkg::CFG_W'(NB)) ? NBW'(NB)
	                                                           : NBW'(active_bits_q);

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			lane_en[i] = NBW'(i) < used_bits;
		end
	end

	// fresh entries start from zero; take the row just written when it was missed
	always_comb begin
		if (new_s2) begin
			row_cur = '0;
		end else if (fwd_s2) begin
			row_cur = fwd_row_s2;
		end else begin
			row_cur = rd_row;
		end
	end

	// all lanes updated in parallel for increment, decrement and test
	always_comb begin
		logic [CW-1:0] cur;
		logic          act;
		row_sub  = row_cur;
		row_uns  = row_cur;
		sat      = 1'b0;
		uflow    = 1'b0;
		all_zero = 1'b1;
		q_ok     = 1'b1;
		for (int i = 0; i < NB; i++) begin
			cur = row_cur[i*CW +: CW];
			act = lane_en[i] && mask_s2[i];
			if (act) begin
				if (cur == rcst_pkg::COUNT_MAX) begin
					sat = 1'b1;
				end else begin
					row_sub[i*CW +: CW] = cur + CW'(1);
				end
				if (cur == '0) begin
					uflow = 1'b1;
					q_ok  = 1'b0;
				end else begin
					row_uns[i*CW +: CW] = cur - CW'(1);
				end
			end
			if (lane_en[i] && (row_uns[i*CW +: CW] != '0)) begin
				all_zero = 1'b0;
			end
		end
	end

	assign row_wr = (mode_s2 == rcst_pkg::MODE_SUB) ? row_sub : row_uns;
	assign s2_wr  = vld_s2 && found_s2 &&
	                ((mode_s2 == rcst_pkg::MODE_SUB) || (mode_s2 == rcst_pkg::MODE_UNSUB));
	assign s2_rm  = vld_s2 && found_s2 && (mode_s2 == rcst_pkg::MODE_UNSUB) && all_zero;

	// result fields
	always_comb begin
		status     = rcst_pkg::ST_OK;
		subscribed = 1'b0;
		case (mode_s2)
			rcst_pkg::MODE_SUB: begin
				if (!found_s2) begin
					status = rcst_pkg::ST_FULL;
				end else if (sat) begin
					status = rcst_pkg::ST_SATURATED;
				end
			end
			rcst_pkg::MODE_UNSUB: begin
				if (!found_s2) begin
					status = rcst_pkg::ST_NOT_FOUND;
				end else if (uflow) begin
					status = rcst_pkg::ST_UNDERFLOW;
				end
			end
			rcst_pkg::MODE_QUERY: begin
				if (!found_s2) begin
					status = rcst_pkg::ST_NOT_FOUND;
				end else begin
					subscribed = q_ok;
				end
			end
			default: begin
				status = rcst_pkg::ST_OK;
			end
		endcase
	end

	// next directory: free the slot emptied by stage two, then apply stage one's change
	always_comb begin
		entry_vld_nxt = entry_vld_q;
		if (s2_adv && s2_rm) begin
			entry_vld_nxt[slot_s2] = 1'b0;
		end
		if (s1_adv) begin
			if (mode_s1 == rcst_pkg::MODE_CLEAR) begin
				entry_vld_nxt = '0;
			end else if (alloc) begin
				entry_vld_nxt[free_slot] = 1'b1;
			end
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= rcst_pkg::ACTIVE_RESET;
			entry_vld_q   <= '0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				active_bits_q <= cfg_wr_data;
			end
			entry_vld_q <= entry_vld_nxt;
			if (in_xfer) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				vld_s2 <= 1'b1;
			end else if (s2_adv) begin
				vld_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1 <= rcst_pkg::mode_t'(s_axis_tdata[MDW-1:0]);
			key_s1  <= s_axis_tdata[MDW +: KW];
			mask_s1 <= s_axis_tdata[MDW+KW +: MW];
		end
		if (s1_adv) begin
			if (alloc) begin
				entry_key_q[free_slot] <= key_s1;
			end
			mode_s2    <= mode_s1;
			mask_s2    <= mask_s1;
			slot_s2    <= slot_s1;
			found_s2   <= found_s1;
			new_s2     <= alloc;
			fwd_s2     <= s2_adv && s2_wr && (slot_s2 == slot_s1);
			fwd_row_s2 <= row_wr;
		end
		if (s2_adv) begin
			out_data_q <= {3'b000, s2_rm, status, subscribed};
		end
	end

	// ---------------- assertions ----------------
	// keys of valid entries stay unique
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $onehot0(match_vec))
		else $error("object id matches more than one entry");

	// a clear leaves the table empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (mode_s1 == rcst_pkg::MODE_CLEAR)) |=> (entry_vld_q == '0))
		else $error("table not empty after clear");

	// an entry is only removed by an unsubscribe that found it
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_data_q[4]) |->
		((out_data_q[3:1] == rcst_pkg::ST_OK) || (out_data_q[3:1] == rcst_pkg::ST_UNDERFLOW)))
		else $error("entry removed with bad status");

	// a positive query answer comes with status ok
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_data_q[0]) |-> (out_data_q[3:1] == rcst_pkg::ST_OK))
		else $error("subscribed answer with bad status");

endmodule

// ----- test/ref_counted_subscription_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ref_counted_subscription_table_tb - self-checking bench for the subscription table
// Drives subscribe, unsubscribe, query and clear requests over the input stream,
// predicts every reply from a private copy of the table and compares each
// result transfer field by field. Covers the directed corner cases, a full
// table and random traffic under several channel counts, with random idling
// on both stream sides.
// ----------------------------------------------------------------------------
module ref_counted_subscription_table_tb;

	localparam int CYCLE_LIMIT = 100000;

	// one reply, laid out as the low bits of the result tdata
	typedef struct packed {
		logic              entry_removed;
		rcst_pkg::status_t status;
		logic              is_subscribed;
	} reply_t;

	// ------------------------------------------------------------------------
	// table mirror and reply checker
	// ------------------------------------------------------------------------
	class subscription_ledger;
		bit                         live [rcst_pkg::TABLE_DEPTH];
		logic [rcst_pkg::KEY_W-1:0] owner [rcst_pkg::TABLE_DEPTH];
		logic [rcst_pkg::CNT_W-1:0] refs [rcst_pkg::TABLE_DEPTH][rcst_pkg::MAX_BITS];
		int unsigned                lanes;
		reply_t                     replies_due [$];
		int                         errors;

		function new();
			lanes  = rcst_pkg::MAX_BITS;
			errors = 0;
			for (int s = 0; s < rcst_pkg::TABLE_DEPTH; s++) live[s] = 1'b0;
		endfunction

		// clamp the channel count to the counters that exist
		function void set_active(logic [rcst_pkg::CFG_W-1:0] value);
			lanes = (value < rcst_pkg::MAX_BITS) ? value : rcst_pkg::MAX_BITS;
		endfunction

		function reply_t predict_reply(rcst_pkg::mode_t m, logic [rcst_pkg::KEY_W-1:0] key,
			logic [rcst_pkg::MASK_W-1:0] mask);
			reply_t r;
			int     slot;
			bit     all_zero;
			r = '0;
			r.status = rcst_pkg::ST_OK;
			if (m == rcst_pkg::MODE_CLEAR) begin
				for (int s = 0; s < rcst_pkg::TABLE_DEPTH; s++) live[s] = 1'b0;
				return r;
			end
			slot = -1;
			for (int s = 0; s < rcst_pkg::TABLE_DEPTH; s++) begin
				if (live[s] && owner[s] == key) begin
					slot = s;
					break;
				end
			end
			if (m == rcst_pkg::MODE_SUB) begin
				// allocate the lowest free slot on a miss
				if (slot < 0) begin
					for (int s = 0; s < rcst_pkg::TABLE_DEPTH; s++) begin
						if (!live[s]) begin
							slot = s;
							break;
						end
					end
					if (slot >= 0) begin
						live[slot]  = 1'b1;
						owner[slot] = key;
						for (int i = 0; i < rcst_pkg::MAX_BITS; i++) refs[slot][i] = '0;
					end
				end
				if (slot < 0) begin
					r.status = rcst_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < lanes; i++) begin
						if (mask[i]) begin
							if (refs[slot][i] == rcst_pkg::COUNT_MAX)
								r.status = rcst_pkg::ST_SATURATED;
							else refs[slot][i] = refs[slot][i] + 1'b1;
						end
					end
				end
			end else if (slot < 0) begin
				r.status = rcst_pkg::ST_NOT_FOUND;
			end else if (m == rcst_pkg::MODE_UNSUB) begin
				// decrement, then free the entry once every active counter is zero
				all_zero = 1'b1;
				for (int i = 0; i < lanes; i++) begin
					if (mask[i]) begin
						if (refs[slot][i] == '0) r.status = rcst_pkg::ST_UNDERFLOW;
						else refs[slot][i] = refs[slot][i] - 1'b1;
					end
					if (refs[slot][i] != '0) all_zero = 1'b0;
				end
				if (all_zero) begin
					live[slot] = 1'b0;
					r.entry_removed = 1'b1;
				end
			end else begin
				r.is_subscribed = 1'b1;
				for (int i = 0; i < lanes; i++)
					if (mask[i] && refs[slot][i] == '0) r.is_subscribed = 1'b0;
			end
			return r;
		endfunction

		function void log_request(rcst_pkg::mode_t m, logic [rcst_pkg::KEY_W-1:0] key,
			logic [rcst_pkg::MASK_W-1:0] mask);
			replies_due.push_back(predict_reply(m, key, mask));
		endfunction

		function void match_reply(logic [rcst_pkg::M_TDATA_W-1:0] data);
			reply_t got;
			reply_t want;
			got = data[4:0];
			if (replies_due.size() == 0) begin
				$error("result transfer with no request pending, tdata %h", data);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.is_subscribed !== want.is_subscribed) begin
				$error("is_subscribed: expected %0d, actual %0d",
					want.is_subscribed, got.is_subscribed);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.entry_removed !== want.entry_removed) begin
				$error("entry_removed: expected %0d, actual %0d",
					want.entry_removed, got.entry_removed);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n        = 1'b0;
	logic                           cfg_wr_en     = 1'b0;
	logic [rcst_pkg::CFG_W-1:0]     cfg_wr_data   = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [rcst_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [rcst_pkg::M_TDATA_W-1:0] m_axis_tdata;

	subscription_ledger ledger;
	bit                 tx_idle_en = 1'b1;
	bit                 rx_idle_en = 1'b1;
	int                 stall_left = 0;
	int                 cycle_count = 0;

	ref_counted_subscription_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// check result transfers and stall the result side in bursts
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) ledger.match_reply(m_axis_tdata);
		if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// abandon a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// present one request and hold it until its transfer
	task automatic send_request(input rcst_pkg::mode_t m,
		input logic [rcst_pkg::KEY_W-1:0] key, input logic [rcst_pkg::MASK_W-1:0] mask);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(rcst_pkg::S_TDATA_W-rcst_pkg::MODE_W-rcst_pkg::KEY_W
			-rcst_pkg::MASK_W){1'b0}}, mask, key, m};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ledger.log_request(m, key, mask);
	endtask

	// hold the input until every pending reply is back
	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.replies_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_active_bits(input logic [rcst_pkg::CFG_W-1:0] value);
		drain_replies();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ledger.set_active(value);
	endtask

	// random traffic over a small pool of keys so that entries are hit again
	task automatic random_phase(input int count, input int pool_size);
		logic [rcst_pkg::KEY_W-1:0]  pool [$];
		logic [rcst_pkg::KEY_W-1:0]  key;
		logic [rcst_pkg::MASK_W-1:0] mask;
		rcst_pkg::mode_t             m;
		int                          pick;
		for (int i = 0; i < pool_size; i++) pool.push_back(rcst_pkg::KEY_W'($urandom()));
		if ($urandom_range(0, 1) == 0) begin
			pool.push_back(16'h8000);
			pool.push_back(16'h7FFF);
			pool.push_back(16'hFFFF);
			pool.push_back(16'h0000);
		end
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) m = rcst_pkg::MODE_CLEAR;
			else if (pick < 38) m = rcst_pkg::MODE_SUB;
			else if (pick < 73) m = rcst_pkg::MODE_UNSUB;
			else m = rcst_pkg::MODE_QUERY;
			if ($urandom_range(0, 19) == 0) key = rcst_pkg::KEY_W'($urandom());
			else key = pool[$urandom_range(0, pool.size() - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 40) mask = rcst_pkg::MASK_W'($urandom());
			else if (pick < 60)
				mask = rcst_pkg::MASK_W'(1) << $urandom_range(0, rcst_pkg::MASK_W - 1);
			else if (pick < 70) mask = rcst_pkg::MASK_W'((1 << ledger.lanes) - 1);
			else if (pick < 75) mask = '0;
			else if (pick < 85) mask = '1;
			else mask = rcst_pkg::MASK_W'($urandom() & $urandom());
			if (tx_idle_en && $urandom_range(0, 63) == 0) drain_replies();
			send_request(m, key, mask);
		end
	endtask

	initial begin
		logic [rcst_pkg::CFG_W-1:0] phase_bits [8];
		int                         phase_pool [8];
		logic [rcst_pkg::KEY_W-1:0] base;
		phase_bits = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd16, 5'd9, 5'd2, 5'd16};
		phase_pool = '{6, 3, 12, 20, 72, 8, 4, 10};
		ledger = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_active_bits(5'd16);

		// misses on an empty table, allocation with an empty mask, extreme keys
		send_request(rcst_pkg::MODE_QUERY, 16'h1234, 16'hFFFF);
		send_request(rcst_pkg::MODE_UNSUB, 16'h1234, 16'hFFFF);
		send_request(rcst_pkg::MODE_SUB,   16'h8000, 16'h0000);
		send_request(rcst_pkg::MODE_QUERY, 16'h8000, 16'h0000);
		send_request(rcst_pkg::MODE_QUERY, 16'h8000, 16'h0001);
		send_request(rcst_pkg::MODE_SUB,   16'h7FFF, 16'hFFFF);
		send_request(rcst_pkg::MODE_QUERY, 16'h7FFF, 16'hFFFF);
		send_request(rcst_pkg::MODE_SUB,   16'h0000, 16'h0001);
		send_request(rcst_pkg::MODE_SUB,   16'hFFFF, 16'h8000);
		// partial release, then full release frees the entry
		send_request(rcst_pkg::MODE_UNSUB, 16'h7FFF, 16'h00FF);
		send_request(rcst_pkg::MODE_UNSUB, 16'h7FFF, 16'hFF00);
		send_request(rcst_pkg::MODE_QUERY, 16'h7FFF, 16'h0001);
		// underflow on an empty counter, with and without freeing
		send_request(rcst_pkg::MODE_UNSUB, 16'h8000, 16'h0001);
		send_request(rcst_pkg::MODE_SUB,   16'h0000, 16'h0001);
		send_request(rcst_pkg::MODE_UNSUB, 16'h0000, 16'h0003);
		// freed slot zero is taken again first
		send_request(rcst_pkg::MODE_SUB,   16'h5555, 16'hAAAA);
		send_request(rcst_pkg::MODE_QUERY, 16'h5555, 16'hAAAA);
		send_request(rcst_pkg::MODE_CLEAR, 16'h0000, 16'h0000);
		send_request(rcst_pkg::MODE_QUERY, 16'hFFFF, 16'h8000);
		// channels above the active count are ignored
		write_active_bits(5'd1);
		send_request(rcst_pkg::MODE_SUB,   16'h0101, 16'hFFFE);
		send_request(rcst_pkg::MODE_QUERY, 16'h0101, 16'hFFFE);
		send_request(rcst_pkg::MODE_UNSUB, 16'h0101, 16'hFFFE);
		write_active_bits(5'd31);
		send_request(rcst_pkg::MODE_SUB,   16'h0202, 16'hFFFF);
		send_request(rcst_pkg::MODE_UNSUB, 16'h0202, 16'hFFFF);

		// fill every slot, then miss on a full table
		write_active_bits(5'd16);
		send_request(rcst_pkg::MODE_CLEAR, 16'h0000, 16'h0000);
		base = rcst_pkg::KEY_W'($urandom());
		for (int i = 0; i < rcst_pkg::TABLE_DEPTH; i++)
			send_request(rcst_pkg::MODE_SUB, base + rcst_pkg::KEY_W'(i),
				rcst_pkg::MASK_W'($urandom()));
		send_request(rcst_pkg::MODE_SUB,
			base + rcst_pkg::KEY_W'(rcst_pkg::TABLE_DEPTH), 16'h0001);
		send_request(rcst_pkg::MODE_QUERY,
			base + rcst_pkg::KEY_W'(rcst_pkg::TABLE_DEPTH), 16'h0001);
		send_request(rcst_pkg::MODE_UNSUB, base + rcst_pkg::KEY_W'(7), 16'hFFFF);
		send_request(rcst_pkg::MODE_UNSUB, base + rcst_pkg::KEY_W'(7), 16'hFFFF);
		send_request(rcst_pkg::MODE_SUB,
			base + rcst_pkg::KEY_W'(rcst_pkg::TABLE_DEPTH), 16'h0001);
		send_request(rcst_pkg::MODE_CLEAR, 16'h0000, 16'h0000);

		// random traffic under several channel counts, last phase at full rate
		for (int p = 0; p < 8; p++) begin
			write_active_bits(phase_bits[p]);
			if (p == 7) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			random_phase(120, phase_pool[p]);
		end

		drain_replies();
		repeat (4) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
